FILE: design/lrub_pkg.sv
// Package of the block buffer tag table: command and status codes,
// the controller states and the tag entry layout. Depends on nothing.
package lrub_pkg;

    localparam int BUFFER_SLOTS_DEF = 32;
    localparam int SLOT_W = 5;
    localparam int IDX_EXT_W = 9;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_SATURATED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SLOT_ISSUE,
        ST_SLOT_RD,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [7:0]  count;
        logic        valid;
    } t_entry;

endpackage

FILE: design/lrub_req_if.sv
// Request channel of the block buffer tag table: valid/ready handshake
// with the command payload. Depends on nothing.
interface lrub_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;

    modport source (output valid, command, device, block_number, slot, input ready);
    modport sink (input valid, command, device, block_number, slot, output ready);
endinterface

FILE: design/lrub_rsp_if.sv
// Response channel of the block buffer tag table: valid/ready handshake
// with the result payload. Depends on nothing.
interface lrub_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_out;
    logic       hit;
    logic       needs_fill;
    logic [1:0] status;

    modport source (output valid, slot_out, hit, needs_fill, status, input ready);
    modport sink (input valid, slot_out, hit, needs_fill, status, output ready);
endinterface

FILE: design/lru_block_buffer_table.sv
// Top level of the block buffer tag table. Depends on lrub_pkg,
// lrub_req_if and lrub_rsp_if.
//
// Tag table of a block buffer cache with reference counts and LRU
// replacement. Each slot holds a device/block tag, a reference count, a
// valid mark and a recency rank (0 is most recent). The whole state sits in
// two synchronous memories (tag entry and rank) with registered read data.
// After reset a clearing pass writes the reset values to every slot; no
// request transaction is accepted during it. One request is processed at
// a time. An acquire walks every slot through the memory read port before
// the response is offered. A release that drops the count to zero walks
// every slot once more to age the ranks. A finished response waits in an
// output register, and the next request transaction is accepted while it
// waits.
module lru_block_buffer_table #(
    parameter int BUFFER_SLOTS = lrub_pkg::BUFFER_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lrub_req_if.sink   i_req,
    lrub_rsp_if.source o_rsp
);

    localparam int W = $clog2(BUFFER_SLOTS);
    localparam logic [W-1:0] LAST = W'(BUFFER_SLOTS - 1);

    // Slot index to the 5 bit response field (low bits of the index).
    function automatic logic [lrub_pkg::SLOT_W-1:0] to_slot(input logic [W-1:0] idx);
        logic [lrub_pkg::IDX_EXT_W-1:0] ext;
        ext = lrub_pkg::IDX_EXT_W'(idx);
        return ext[lrub_pkg::SLOT_W-1:0];
    endfunction

    // Storage: tag entries and recency ranks share addresses.
    lrub_pkg::t_entry mem_tag [BUFFER_SLOTS];
    logic [W-1:0]     mem_rank [BUFFER_SLOTS];

    logic             mem_we;
    logic [W-1:0]     mem_wa;
    lrub_pkg::t_entry mem_wtag;
    logic [W-1:0]     mem_wrank;
    logic [W-1:0]     mem_ra;
    lrub_pkg::t_entry r_rd_tag;
    logic [W-1:0]     r_rd_rank;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tag[mem_wa]  <= mem_wtag;
            mem_rank[mem_wa] <= mem_wrank;
        end
        r_rd_tag  <= mem_tag[mem_ra];
        r_rd_rank <= mem_rank[mem_ra];
    end

    // Control state.
    lrub_pkg::t_state r_state, n_state;
    logic [W-1:0]     r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_rd_vld, n_rd_vld;
    logic [W-1:0]     r_rd_idx, n_rd_idx;
    logic             r_ov, n_ov;

    // Request and working registers (no reset needed).
    lrub_pkg::t_cmd   r_cmd, n_cmd;
    logic [7:0]       r_dev, n_dev;
    logic [31:0]      r_blk, n_blk;
    logic [lrub_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [W-1:0]     r_sidx, n_sidx;
    logic [W-1:0]     r_srank, n_srank;
    logic             r_hfound, n_hfound;
    logic [W-1:0]     r_hidx, n_hidx;
    logic [W-1:0]     r_hrank, n_hrank;
    logic [7:0]       r_hcnt, n_hcnt;
    logic             r_hval, n_hval;
    logic             r_ffound, n_ffound;
    logic [W-1:0]     r_fidx, n_fidx;
    logic [W-1:0]     r_frank, n_frank;
    logic [lrub_pkg::SLOT_W-1:0] r_res_slot, n_res_slot;
    logic             r_res_hit, n_res_hit;
    logic             r_res_nf, n_res_nf;
    lrub_pkg::t_status r_res_st, n_res_st;
    logic [lrub_pkg::SLOT_W-1:0] r_o_slot, n_o_slot;
    logic             r_o_hit, n_o_hit;
    logic             r_o_nf, n_o_nf;
    lrub_pkg::t_status r_o_st, n_o_st;

    logic [lrub_pkg::IDX_EXT_W-1:0] slot_ext;
    logic in_range;
    logic tag_match;

    assign slot_ext  = lrub_pkg::IDX_EXT_W'(i_req.slot);
    assign in_range  = slot_ext < lrub_pkg::IDX_EXT_W'(BUFFER_SLOTS);
    assign tag_match = (r_rd_tag.device == r_dev) && (r_rd_tag.block_number == r_blk);

    assign i_req.ready      = (r_state == lrub_pkg::ST_IDLE);
    assign o_rsp.valid      = r_ov;
    assign o_rsp.slot_out   = r_o_slot;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.needs_fill = r_o_nf;
    assign o_rsp.status     = r_o_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lrub_pkg::ST_CLEAR;
            r_idx    <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmd      <= n_cmd;
        r_dev      <= n_dev;
        r_blk      <= n_blk;
        r_slot     <= n_slot;
        r_sidx     <= n_sidx;
        r_srank    <= n_srank;
        r_hfound   <= n_hfound;
        r_hidx     <= n_hidx;
        r_hrank    <= n_hrank;
        r_hcnt     <= n_hcnt;
        r_hval     <= n_hval;
        r_ffound   <= n_ffound;
        r_fidx     <= n_fidx;
        r_frank    <= n_frank;
        r_res_slot <= n_res_slot;
        r_res_hit  <= n_res_hit;
        r_res_nf   <= n_res_nf;
        r_res_st   <= n_res_st;
        r_o_slot   <= n_o_slot;
        r_o_hit    <= n_o_hit;
        r_o_nf     <= n_o_nf;
        r_o_st     <= n_o_st;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_idx;
        n_cmd      = r_cmd;
        n_dev      = r_dev;
        n_blk      = r_blk;
        n_slot     = r_slot;
        n_sidx     = r_sidx;
        n_srank    = r_srank;
        n_hfound   = r_hfound;
        n_hidx     = r_hidx;
        n_hrank    = r_hrank;
        n_hcnt     = r_hcnt;
        n_hval     = r_hval;
        n_ffound   = r_ffound;
        n_fidx     = r_fidx;
        n_frank    = r_frank;
        n_res_slot = r_res_slot;
        n_res_hit  = r_res_hit;
        n_res_nf   = r_res_nf;
        n_res_st   = r_res_st;
        n_o_slot   = r_o_slot;
        n_o_hit    = r_o_hit;
        n_o_nf     = r_o_nf;
        n_o_st     = r_o_st;
        n_ov       = r_ov && !o_rsp.ready;

        mem_we    = 1'b0;
        mem_wa    = r_rd_idx;
        mem_wtag  = r_rd_tag;
        mem_wrank = r_rd_rank;
        mem_ra    = r_idx;

        case (r_state)
            lrub_pkg::ST_CLEAR: begin
                // Write the reset values, one slot a cycle.
                mem_we    = 1'b1;
                mem_wa    = r_idx;
                mem_wtag  = '0;
                mem_wrank = LAST - r_idx;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = lrub_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lrub_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_cmd      = lrub_pkg::t_cmd'(i_req.command);
                    n_dev      = i_req.device;
                    n_blk      = i_req.block_number;
                    n_slot     = i_req.slot;
                    n_sidx     = slot_ext[W-1:0];
                    n_hfound   = 1'b0;
                    n_ffound   = 1'b0;
                    n_idx      = '0;
                    n_res_slot = i_req.slot;
                    n_res_hit  = 1'b0;
                    n_res_nf   = 1'b0;
                    n_res_st   = lrub_pkg::STAT_OK;
                    if (lrub_pkg::t_cmd'(i_req.command) == lrub_pkg::CMD_ACQUIRE) begin
                        n_issue = 1'b1;
                        n_state = lrub_pkg::ST_SCAN;
                    end else if (in_range) begin
                        n_state = lrub_pkg::ST_SLOT_ISSUE;
                    end else begin
                        // An index beyond the table is answered as is.
                        n_state = lrub_pkg::ST_DONE;
                    end
                end
            end
            lrub_pkg::ST_SCAN: begin
                // Issue one read a cycle; judge the data that comes back.
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (tag_match && (!r_hfound || r_rd_rank < r_hrank)) begin
                        n_hfound = 1'b1;
                        n_hidx   = r_rd_idx;
                        n_hrank  = r_rd_rank;
                        n_hcnt   = r_rd_tag.count;
                        n_hval   = r_rd_tag.valid;
                    end
                    if ((r_rd_tag.count == 8'd0) && (!r_ffound || r_rd_rank > r_frank)) begin
                        n_ffound = 1'b1;
                        n_fidx   = r_rd_idx;
                        n_frank  = r_rd_rank;
                    end
                    if (!r_issue) begin
                        n_state = lrub_pkg::ST_DECIDE;
                    end
                end
            end
            lrub_pkg::ST_DECIDE: begin
                mem_wtag.device       = r_dev;
                mem_wtag.block_number = r_blk;
                mem_wtag.valid        = 1'b1;
                n_state               = lrub_pkg::ST_DONE;
                if (r_hfound) begin
                    n_res_slot = to_slot(r_hidx);
                    n_res_hit  = 1'b1;
                    if (r_hcnt == lrub_pkg::COUNT_MAX) begin
                        n_res_st = lrub_pkg::STAT_SATURATED;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wa         = r_hidx;
                        mem_wtag.count = r_hcnt + 8'd1;
                        mem_wrank      = r_hrank;
                        n_res_nf       = !r_hval;
                    end
                end else if (r_ffound) begin
                    // Retag the least recent unreferenced slot.
                    mem_we         = 1'b1;
                    mem_wa         = r_fidx;
                    mem_wtag.count = 8'd1;
                    mem_wrank      = r_frank;
                    n_res_slot     = to_slot(r_fidx);
                    n_res_nf       = 1'b1;
                end else begin
                    n_res_slot = '0;
                    n_res_st   = lrub_pkg::STAT_NO_FREE;
                end
            end
            lrub_pkg::ST_SLOT_ISSUE: begin
                mem_ra  = r_sidx;
                n_state = lrub_pkg::ST_SLOT_RD;
            end
            lrub_pkg::ST_SLOT_RD: begin
                mem_wa  = r_sidx;
                n_state = lrub_pkg::ST_DONE;
                if (r_cmd == lrub_pkg::CMD_PIN) begin
                    if (r_rd_tag.count == lrub_pkg::COUNT_MAX) begin
                        n_res_st = lrub_pkg::STAT_SATURATED;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wtag.count = r_rd_tag.count + 8'd1;
                    end
                end else if (r_rd_tag.count == 8'd0) begin
                    n_res_st = lrub_pkg::STAT_UNDERFLOW;
                end else if (r_cmd == lrub_pkg::CMD_RELEASE && r_rd_tag.count == 8'd1) begin
                    // Count reaches zero: age the newer slots in a full sweep.
                    n_srank = r_rd_rank;
                    n_idx   = '0;
                    n_issue = 1'b1;
                    n_state = lrub_pkg::ST_SWEEP;
                end else begin
                    mem_we         = 1'b1;
                    mem_wtag.count = r_rd_tag.count - 8'd1;
                end
            end
            lrub_pkg::ST_SWEEP: begin
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    mem_we = 1'b1;
                    if (r_rd_idx == r_sidx) begin
                        mem_wtag.count = 8'd0;
                        mem_wrank      = '0;
                    end else if (r_rd_rank < r_srank) begin
                        mem_wrank = r_rd_rank + 1'b1;
                    end
                    if (!r_issue) begin
                        n_state = lrub_pkg::ST_DONE;
                    end
                end
            end
            lrub_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov     = 1'b1;
                    n_o_slot = r_res_slot;
                    n_o_hit  = r_res_hit;
                    n_o_nf   = r_res_nf;
                    n_o_st   = r_res_st;
                    n_state  = lrub_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrub_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
